FILE: src/ipd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ipd_pkg;

  // input transaction kinds carried on in_tuser
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_EOF  = 1'b1;

  // result kinds carried on out_tuser
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  // error codes
  localparam logic [1:0] ERR_NONE         = 2'd0;
  localparam logic [1:0] ERR_HEADER_SHORT = 2'd1;
  localparam logic [1:0] ERR_ZERO_SIZE    = 2'd2;
  localparam logic [1:0] ERR_DATA_SHORT   = 2'd3;

  // decode phases
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_PIXELS = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  // header byte positions of the little-endian size fields
  localparam int WIDTH_LO_POS  = 2;
  localparam int WIDTH_HI_POS  = 3;
  localparam int HEIGHT_LO_POS = 4;
  localparam int HEIGHT_HI_POS = 5;

  // palette components per entry and number of byte codes
  localparam int COMPONENTS = 3;
  localparam int BYTE_CODES = 256;

  localparam logic [1:0] COMP_RED   = 2'd0;
  localparam logic [1:0] COMP_GREEN = 2'd1;
  localparam logic [1:0] COMP_BLUE  = 2'd2;

  // everything a result carries apart from the colour
  typedef struct packed {
    logic        kind;
    logic [15:0] width;
    logic [15:0] height;
    logic [1:0]  code;
    logic        last;
  } res_meta_t;

endpackage

`default_nettype wire

FILE: src/indexed_image_palette_decoder_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Palette image decoder. One transaction per cycle is taken on the input: a
// file byte, or an end-of-file mark that reports any short header, palette or
// pixel data and then readies the block for the next file. The header gives
// width and height, the palette bytes are gathered into RGB words and written
// to the palette memory, and each later byte is looked up there and leaves
// as one pixel through the lookup stage and the output register, with the
// last pixel marked on out_tlast. The palette memory's one read port sets the
// rate: one pixel per cycle, sustained with no gaps while the output side
// takes transactions. The input stalls only when both the lookup stage and
// the output register hold results. No clearing pass is needed after reset.
module indexed_image_palette_decoder_core
  import ipd_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 256,
  parameter int HEADER_BYTES    = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tuser,   // [0] operation
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // [7:0] red, [15:8] green, [23:16] blue,
                                       // [39:24] image_width, [55:40] image_height,
                                       // [57:56] error_code, [63:58] zero
  output logic             out_tuser,  // [0] result_kind
  output logic             out_tlast   // last_of_image
);

  localparam int PALETTE_END = HEADER_BYTES + COMPONENTS * PALETTE_ENTRIES;
  localparam int POS_W       = $clog2(PALETTE_END);
  localparam int IDX_W       = $clog2(PALETTE_ENTRIES);

  // byte code to palette index, wrapped to the palette size
  logic [IDX_W-1:0] idx_tbl [BYTE_CODES];

  for (genvar g = 0; g < BYTE_CODES; g++) begin : g_idx
    assign idx_tbl[g] = IDX_W'(g % PALETTE_ENTRIES);
  end

  // decode state
  logic [1:0]       phase_r, phase_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]      width_r, width_nxt;
  logic [15:0]      height_r, height_nxt;
  logic [31:0]      pix_left_r, pix_left_nxt;
  logic [1:0]       comp_r, comp_nxt;
  logic [IDX_W-1:0] ent_r, ent_nxt;
  logic [7:0]       red_r, red_nxt;
  logic [7:0]       green_r, green_nxt;
  logic [31:0]      prod_r;

  // palette memory
  logic [23:0]      pal_mem [PALETTE_ENTRIES];
  logic             wr_en;
  logic [23:0]      wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [23:0]      rd_data_r;

  // lookup stage and output register
  logic             s1_v_r;
  res_meta_t        s1_meta_r;
  logic             s1_load;
  res_meta_t        meta_nxt;
  logic             s1_adv;
  logic             o_v_r;
  res_meta_t        o_meta_r;
  logic [23:0]      o_rgb_r;
  logic             in_fire;
  logic [7:0]       byte_in;

  assign s1_adv    = !o_v_r || out_tready;
  assign in_tready = !s1_v_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;
  assign byte_in   = in_tdata;
  assign rd_addr   = idx_tbl[byte_in];
  assign wr_data   = {red_r, green_r, byte_in};

  // decode control
  always_comb begin
    phase_nxt    = phase_r;
    pos_nxt      = pos_r;
    width_nxt    = width_r;
    height_nxt   = height_r;
    pix_left_nxt = pix_left_r;
    comp_nxt     = comp_r;
    ent_nxt      = ent_r;
    red_nxt      = red_r;
    green_nxt    = green_r;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    s1_load      = 1'b0;
    meta_nxt     = '{kind: KIND_ERROR, width: width_r, height: height_r,
                     code: ERR_NONE, last: 1'b0};
    if (in_fire) begin
      if (in_tuser == OP_EOF) begin
        // end of file: report anything incomplete, then start over
        if (phase_r == PH_HEADER) begin
          s1_load       = 1'b1;
          meta_nxt.code = ERR_HEADER_SHORT;
        end else if (phase_r == PH_PIXELS && pix_left_r != '0) begin
          s1_load       = 1'b1;
          meta_nxt.code = ERR_DATA_SHORT;
        end
        phase_nxt    = PH_HEADER;
        pos_nxt      = '0;
        width_nxt    = '0;
        height_nxt   = '0;
        pix_left_nxt = '0;
        comp_nxt     = COMP_RED;
        ent_nxt      = '0;
      end else begin
        unique case (phase_r)
          PH_HEADER: begin
            pos_nxt = pos_r + POS_W'(1);
            if (pos_r == POS_W'(WIDTH_LO_POS)) begin
              width_nxt[7:0] = byte_in;
            end else if (pos_r == POS_W'(WIDTH_HI_POS)) begin
              width_nxt[15:8] = byte_in;
            end else if (pos_r == POS_W'(HEIGHT_LO_POS)) begin
              height_nxt[7:0] = byte_in;
            end else if (pos_r == POS_W'(HEIGHT_HI_POS)) begin
              height_nxt[15:8] = byte_in;
              if (width_r == '0 || height_nxt == '0) begin
                s1_load         = 1'b1;
                meta_nxt.code   = ERR_ZERO_SIZE;
                meta_nxt.height = height_nxt;
                phase_nxt       = PH_DONE;
              end
            end else if (pos_r >= POS_W'(HEADER_BYTES)) begin
              // gather red and green, write the entry on blue
              case (comp_r)
                COMP_RED: begin
                  red_nxt  = byte_in;
                  comp_nxt = COMP_GREEN;
                end
                COMP_GREEN: begin
                  green_nxt = byte_in;
                  comp_nxt  = COMP_BLUE;
                end
                default: begin
                  wr_en    = 1'b1;
                  comp_nxt = COMP_RED;
                  ent_nxt  = ent_r + IDX_W'(1);
                end
              endcase
            end
            if (pos_r == POS_W'(PALETTE_END - 1)) begin
              phase_nxt    = PH_PIXELS;
              pix_left_nxt = prod_r;
            end
          end
          PH_PIXELS: begin
            rd_en         = 1'b1;
            s1_load       = 1'b1;
            pix_left_nxt  = pix_left_r - 32'd1;
            meta_nxt.kind = KIND_PIXEL;
            meta_nxt.last = (pix_left_r == 32'd1);
            if (pix_left_r == 32'd1) begin
              phase_nxt = PH_DONE;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // decode state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      pos_r      <= '0;
      width_r    <= '0;
      height_r   <= '0;
      pix_left_r <= '0;
      comp_r     <= COMP_RED;
      ent_r      <= '0;
    end else begin
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      width_r    <= width_nxt;
      height_r   <= height_nxt;
      pix_left_r <= pix_left_nxt;
      comp_r     <= comp_nxt;
      ent_r      <= ent_nxt;
    end
  end

  // colour gathering and pixel count product
  always_ff @(posedge clk) begin
    red_r   <= red_nxt;
    green_r <= green_nxt;
    prod_r  <= {16'd0, width_r} * {16'd0, height_r};
  end

  // palette memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      pal_mem[ent_r] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= pal_mem[rd_addr];
    end
  end

  // result pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      if (s1_adv) begin
        o_v_r <= s1_v_r;
      end
      if (in_tready) begin
        s1_v_r <= s1_load;
      end
    end
  end

  // result pipeline payload
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_meta_r <= meta_nxt;
    end
    if (s1_adv && s1_v_r) begin
      o_meta_r <= s1_meta_r;
      o_rgb_r  <= (s1_meta_r.kind == KIND_PIXEL) ? rd_data_r : 24'd0;
    end
  end

  assign out_tvalid = o_v_r;
  assign out_tuser  = o_meta_r.kind;
  assign out_tlast  = o_meta_r.last;
  assign out_tdata  = {6'd0, o_meta_r.code, o_meta_r.height, o_meta_r.width,
                       o_rgb_r[7:0], o_rgb_r[15:8], o_rgb_r[23:16]};

  // checks
  a_pix_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PIXELS |-> pix_left_r != '0)
    else $error("pixel phase with no pixels left");

  a_pixel_byte_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tuser == OP_BYTE && phase_r == PH_PIXELS |=> s1_v_r)
    else $error("pixel byte did not enter the lookup stage");

  a_last_ends_image: assert property (@(posedge clk) disable iff (!rst_n)
    s1_load && meta_nxt.kind == KIND_PIXEL && meta_nxt.last |=> phase_r == PH_DONE)
    else $error("last pixel did not finish the image");

  a_last_is_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == KIND_PIXEL)
    else $error("last flag on an error report");

  a_no_write_in_pixels: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> !wr_en && phase_r == PH_PIXELS)
    else $error("palette read outside the pixel phase");

endmodule

`default_nettype wire
